// ===== hw/rtl/knpi_pkg.sv =====
// Package for the k nearest point index selector.
// Types, widths and command codes; no dependencies.
package knpi_pkg;
	localparam int MaxPoints = 256;
	localparam int MaxSelect = 64;
	localparam int CoordBits = 24;
	localparam int IdxBits = $clog2(MaxPoints);
	localparam int CntBits = $clog2(MaxPoints + 1);
	localparam int DistBits = 2 * CoordBits + 2;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_LOAD = 2'd1,
		CMD_QUERY = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic signed [23:0] pos_x;
		logic signed [23:0] pos_y;
		logic signed [23:0] pos_z;
		logic excluded;
		logic [6:0] want_count;
		logic valence_only;
	} in_item_t;

	typedef struct packed {
		logic [7:0] point_index;
		logic last;
		logic status;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIST,
		ST_CHECK,
		ST_SELECT,
		ST_EMIT,
		ST_ERROR
	} state_t;
endpackage

// ===== hw/rtl/knpi_dist.sv =====
// Squared Euclidean distance, two register stages.
// Depends on knpi_pkg.
module knpi_dist (
	input logic clk,
	input logic [knpi_pkg::CoordBits-1:0] ax,
	input logic [knpi_pkg::CoordBits-1:0] ay,
	input logic [knpi_pkg::CoordBits-1:0] az,
	input logic [knpi_pkg::CoordBits-1:0] bx,
	input logic [knpi_pkg::CoordBits-1:0] by,
	input logic [knpi_pkg::CoordBits-1:0] bz,
	output logic [knpi_pkg::DistBits-1:0] sqd
);
	localparam int CB = knpi_pkg::CoordBits;
	logic [CB:0] dx, dy, dz;
	logic [2*CB-1:0] sx_s1, sy_s1, sz_s1;

	function automatic logic [CB:0] absdiff(logic [CB-1:0] a, logic [CB-1:0] b);
		logic signed [CB:0] d;
		d = $signed({a[CB-1], a}) - $signed({b[CB-1], b});
		return d[CB] ? -d : d;
	endfunction

	always_comb begin
		dx = absdiff(ax, bx);
		dy = absdiff(ay, by);
		dz = absdiff(az, bz);
	end

	always_ff @(posedge clk) begin
		sx_s1 <= (2*CB)'(dx * dx);
		sy_s1 <= (2*CB)'(dy * dy);
		sz_s1 <= (2*CB)'(dz * dz);
		sqd <= knpi_pkg::DistBits'(sx_s1) + knpi_pkg::DistBits'(sy_s1)
			+ knpi_pkg::DistBits'(sz_s1);
	end
endmodule

// ===== hw/rtl/knpi_store.sv =====
// Point memory and distance memory, synchronous read.
// Depends on knpi_pkg.
module knpi_store (
	input logic clk,
	input logic pt_we,
	input logic [knpi_pkg::IdxBits-1:0] pt_waddr,
	input logic [3*knpi_pkg::CoordBits:0] pt_wdata,
	input logic [knpi_pkg::IdxBits-1:0] pt_raddr,
	output logic [3*knpi_pkg::CoordBits:0] pt_rdata,
	input logic d_we,
	input logic [knpi_pkg::IdxBits-1:0] d_waddr,
	input logic [knpi_pkg::DistBits:0] d_wdata,
	input logic [knpi_pkg::IdxBits-1:0] d_raddr,
	output logic [knpi_pkg::DistBits:0] d_rdata
);
	logic [3*knpi_pkg::CoordBits:0] pt_mem [knpi_pkg::MaxPoints];
	// distance entry: {chosen flag, squared distance}
	logic [knpi_pkg::DistBits:0] d_mem [knpi_pkg::MaxPoints];

	always_ff @(posedge clk) begin
		if (pt_we) begin
			pt_mem[pt_waddr] <= pt_wdata;
		end
		pt_rdata <= pt_mem[pt_raddr];
	end

	always_ff @(posedge clk) begin
		if (d_we) begin
			d_mem[d_waddr] <= d_wdata;
		end
		d_rdata <= d_mem[d_raddr];
	end
endmodule

// ===== hw/rtl/k_nearest_point_indices_core.sv =====
// k nearest point selector, top level. Depends on knpi_pkg, knpi_dist, knpi_store.
// Clear and load are taken in idle. Query: a distance pass over the point set writes
// distances into the distance memory, then want_count selection rounds each scan the set,
// then an emit scan runs up to the last chosen entry, held by any output stalls; an
// error is one output transfer. One item in flight at a time.
// Reset (arst_n low) empties the point set and idles the controller.
module k_nearest_point_indices_core (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input knpi_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output knpi_pkg::out_item_t out_data
);
	localparam int IB = knpi_pkg::IdxBits;
	localparam int CNB = knpi_pkg::CntBits;
	localparam int DB = knpi_pkg::DistBits;
	localparam int CB = knpi_pkg::CoordBits;

	knpi_pkg::state_t state_q, state_d;
	logic [CNB-1:0] count_q;
	logic [CNB-1:0] scan_q;      // address being issued
	logic [CNB-1:0] cnt_eligible_q;
	logic [6:0] round_q, emitted_q;
	logic [6:0] want_q;
	logic valence_q;
	logic [CB-1:0] qx_q, qy_q, qz_q;
	// pipeline for the scan: read valid / index
	logic rv_s1, rv_s2, rv_s3;
	logic [IB-1:0] ri_s1, ri_s2, ri_s3;
	logic have_q;
	logic [IB-1:0] best_q;
	logic [DB-1:0] bestd_q;

	logic [3*CB:0] pt_rdata;
	// chosen flag rides in the top bit of each distance entry; the distance pass
	// rewrites every scanned entry with the flag clear
	logic [DB:0] d_rdata, d_wdata;
	logic [DB-1:0] sqd;
	logic d_we;
	logic [IB-1:0] d_waddr;
	logic [IB-1:0] rd_addr;
	logic emit_stall;
	logic round_end;
	logic accept_in, accept_out;
	logic pt_we;
	logic scan_end;

	assign accept_in = in_valid && in_ready;
	assign accept_out = out_valid && out_ready;
	assign scan_end = (scan_q == count_q);
	assign round_end = (state_q == knpi_pkg::ST_SELECT) && scan_end && !rv_s1;

	// a stalled output re-reads the entry on display so the payload holds
	assign emit_stall = out_valid && !out_ready;
	assign rd_addr = emit_stall ? ri_s1 : scan_q[IB-1:0];

	assign pt_we = accept_in && in_data.cmd == knpi_pkg::CMD_LOAD
		&& count_q != CNB'(knpi_pkg::MaxPoints);

	// distance memory writes: fresh distances in the distance pass,
	// chosen flag on the round winner at the end of each round
	always_comb begin
		d_we = 1'b0;
		d_waddr = ri_s3;
		d_wdata = {1'b0, sqd};
		case (state_q)
			knpi_pkg::ST_DIST: d_we = rv_s3;
			knpi_pkg::ST_SELECT: begin
				d_we = round_end && have_q;
				d_waddr = best_q;
				d_wdata = {1'b1, bestd_q};
			end
			default: ;
		endcase
	end

	knpi_store u_store (
		.clk(clk),
		.pt_we(pt_we),
		.pt_waddr(count_q[IB-1:0]),
		.pt_wdata({in_data.excluded, in_data.pos_x, in_data.pos_y, in_data.pos_z}),
		.pt_raddr(scan_q[IB-1:0]),
		.pt_rdata(pt_rdata),
		.d_we(d_we),
		.d_waddr(d_waddr),
		.d_wdata(d_wdata),
		.d_raddr(rd_addr),
		.d_rdata(d_rdata)
	);

	knpi_dist u_dist (
		.clk(clk),
		.ax(pt_rdata[3*CB-1:2*CB]), .ay(pt_rdata[2*CB-1:CB]), .az(pt_rdata[CB-1:0]),
		.bx(qx_q), .by(qy_q), .bz(qz_q),
		.sqd(sqd)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			knpi_pkg::ST_IDLE: begin
				if (accept_in && in_data.cmd == knpi_pkg::CMD_QUERY && in_data.want_count != '0)
					state_d = knpi_pkg::ST_DIST;
			end
			knpi_pkg::ST_DIST: begin
				if (scan_end && !rv_s1 && !rv_s2 && !rv_s3)
					state_d = knpi_pkg::ST_CHECK;
			end
			knpi_pkg::ST_CHECK: begin
				if (want_q > 7'(knpi_pkg::MaxSelect) || CNB'(want_q) > cnt_eligible_q)
					state_d = knpi_pkg::ST_ERROR;
				else
					state_d = knpi_pkg::ST_SELECT;
			end
			knpi_pkg::ST_SELECT: begin
				if (scan_end && !rv_s1 && round_q + 7'd1 == want_q)
					state_d = knpi_pkg::ST_EMIT;
			end
			knpi_pkg::ST_EMIT: begin
				if (accept_out && emitted_q + 7'd1 == want_q)
					state_d = knpi_pkg::ST_IDLE;
			end
			knpi_pkg::ST_ERROR: begin
				if (accept_out)
					state_d = knpi_pkg::ST_IDLE;
			end
			default: state_d = knpi_pkg::ST_IDLE;
		endcase
	end

	// outputs: emit shows the entry read last cycle when its chosen flag is set
	always_comb begin
		in_ready = (state_q == knpi_pkg::ST_IDLE);
		out_valid = 1'b0;
		out_data = '0;
		case (state_q)
			knpi_pkg::ST_EMIT: begin
				out_valid = rv_s1 && d_rdata[DB];
				out_data.point_index = 8'(ri_s1);
				out_data.last = (emitted_q + 7'd1 == want_q);
			end
			knpi_pkg::ST_ERROR: begin
				out_valid = 1'b1;
				out_data.last = 1'b1;
				out_data.status = 1'b1;
			end
			default: ;
		endcase
	end

	logic cand_ok, better;
	always_comb begin
		cand_ok = rv_s1 && !d_rdata[DB] && !(valence_q && pt_rdata[3*CB]);
		better = !have_q || d_rdata[DB-1:0] <= bestd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= knpi_pkg::ST_IDLE;
			count_q <= '0;
			scan_q <= '0;
			rv_s1 <= 1'b0;
			rv_s2 <= 1'b0;
			rv_s3 <= 1'b0;
			have_q <= 1'b0;
			round_q <= '0;
			emitted_q <= '0;
			cnt_eligible_q <= '0;
		end else begin
			state_q <= state_d;
			rv_s1 <= 1'b0;
			rv_s2 <= rv_s1;
			rv_s3 <= rv_s2;
			if (accept_in) begin
				if (in_data.cmd == knpi_pkg::CMD_CLEAR)
					count_q <= '0;
				if (pt_we)
					count_q <= count_q + CNB'(1);
				if (in_data.cmd == knpi_pkg::CMD_QUERY) begin
					scan_q <= '0;
					cnt_eligible_q <= '0;
					round_q <= '0;
					emitted_q <= '0;
					have_q <= 1'b0;
				end
			end
			case (state_q)
				knpi_pkg::ST_DIST: begin
					if (!scan_end) begin
						rv_s1 <= 1'b1;
						scan_q <= scan_q + CNB'(1);
					end
					if (rv_s1 && !(valence_q && pt_rdata[3*CB]))
						cnt_eligible_q <= cnt_eligible_q + CNB'(1);
					if (state_d == knpi_pkg::ST_CHECK)
						scan_q <= '0;
				end
				knpi_pkg::ST_SELECT: begin
					if (!scan_end) begin
						rv_s1 <= 1'b1;
						scan_q <= scan_q + CNB'(1);
					end
					if (cand_ok && better) begin
						have_q <= 1'b1;
						best_q <= ri_s1;
						bestd_q <= d_rdata[DB-1:0];
					end
					if (round_end) begin
						have_q <= 1'b0;
						round_q <= round_q + 7'd1;
						scan_q <= '0;
					end
				end
				knpi_pkg::ST_EMIT: begin
					if (!emit_stall)
						scan_q <= scan_q + CNB'(1);
					if (state_d == knpi_pkg::ST_EMIT)
						rv_s1 <= 1'b1;
					if (accept_out)
						emitted_q <= emitted_q + 7'd1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		ri_s1 <= rd_addr;
		ri_s2 <= ri_s1;
		ri_s3 <= ri_s2;
		if (accept_in && in_data.cmd == knpi_pkg::CMD_QUERY) begin
			qx_q <= in_data.pos_x;
			qy_q <= in_data.pos_y;
			qz_q <= in_data.pos_z;
			want_q <= in_data.want_count;
			valence_q <= in_data.valence_only;
		end
	end

`ifndef SYNTHESIS
	// point count never exceeds capacity
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNB'(knpi_pkg::MaxPoints))
		else $error("point count overflow");
	// a waiting output transfer holds its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("output changed while stalled");
	// no input transfer while a query is busy
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != knpi_pkg::ST_IDLE) |-> !in_ready)
		else $error("input taken while busy");
`endif
endmodule

// ===== dv/tb_k_nearest_point_indices_core.sv =====
// Testbench for k_nearest_point_indices_core: random and directed clear/load/query traffic.
// Depends on knpi_pkg; a scoreboard class predicts the selected indices of each query.
module tb_k_nearest_point_indices_core;

	class knn_scoreboard;
		logic [23:0] px[knpi_pkg::MaxPoints];
		logic [23:0] py[knpi_pkg::MaxPoints];
		logic [23:0] pz[knpi_pkg::MaxPoints];
		bit core[knpi_pkg::MaxPoints];
		int unsigned npts;
		knpi_pkg::out_item_t pending[$];
		int errors;

		function void reset_state();
			npts = 0;
			pending.delete();
			errors = 0;
		endfunction

		function logic [49:0] sqdist(int i, knpi_pkg::in_item_t it);
			logic signed [25:0] dx, dy, dz;
			dx = $signed(px[i]) - $signed(it.pos_x);
			dy = $signed(py[i]) - $signed(it.pos_y);
			dz = $signed(pz[i]) - $signed(it.pos_z);
			return 50'(dx * dx) + 50'(dy * dy) + 50'(dz * dz);
		endfunction

		// Note one accepted input transfer and queue what it should produce.
		function void note_input(knpi_pkg::in_item_t it);
			logic [49:0] d[knpi_pkg::MaxPoints];
			bit picked[knpi_pkg::MaxPoints];
			int elig, best, k;
			knpi_pkg::out_item_t o;
			case (knpi_pkg::cmd_t'(it.cmd))
				knpi_pkg::CMD_CLEAR: npts = 0;
				knpi_pkg::CMD_LOAD: begin
					if (npts < knpi_pkg::MaxPoints) begin
						px[npts] = it.pos_x;
						py[npts] = it.pos_y;
						pz[npts] = it.pos_z;
						core[npts] = it.excluded;
						npts++;
					end
				end
				knpi_pkg::CMD_QUERY: begin
					if (it.want_count != 0) begin
						elig = 0;
						for (int i = 0; i < npts; i++) begin
							d[i] = sqdist(i, it);
							picked[i] = 1'b0;
							if (!(it.valence_only && core[i])) elig++;
						end
						if (it.want_count > knpi_pkg::MaxSelect || it.want_count > elig) begin
							o.point_index = 8'd0;
							o.last = 1'b1;
							o.status = 1'b1;
							pending.push_back(o);
						end else begin
							for (int r = 0; r < it.want_count; r++) begin
								best = -1;
								for (int i = 0; i < npts; i++) begin
									if (picked[i] || (it.valence_only && core[i])) continue;
									// ties go to the later index
									if (best < 0 || d[i] <= d[best]) best = i;
								end
								picked[best] = 1'b1;
							end
							k = 0;
							for (int i = 0; i < npts; i++) begin
								if (picked[i]) begin
									k++;
									o.point_index = 8'(i);
									o.last = (k == it.want_count);
									o.status = 1'b0;
									pending.push_back(o);
								end
							end
						end
					end
				end
				default: ;
			endcase
		endfunction

		function void check_result(knpi_pkg::out_item_t got);
			knpi_pkg::out_item_t exp_item;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result idx=%0d last=%0b status=%0b",
					$time, got.point_index, got.last, got.status);
				errors++;
				return;
			end
			exp_item = pending.pop_front();
			if (got.point_index !== exp_item.point_index)
				$display("%0t: point_index expected %0d actual %0d", $time,
					exp_item.point_index, got.point_index);
			if (got.last !== exp_item.last)
				$display("%0t: last expected %0b actual %0b", $time, exp_item.last, got.last);
			if (got.status !== exp_item.status)
				$display("%0t: status expected %0b actual %0b", $time,
					exp_item.status, got.status);
			if (got !== exp_item) errors++;
		endfunction
	endclass

	localparam int WatchLimit = 400000;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	knpi_pkg::in_item_t in_data;
	knpi_pkg::out_item_t out_data;
	knn_scoreboard sb;
	bit hold_long;
	int idle_cycles = 0;

	k_nearest_point_indices_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// Scoreboard taps both channels on the same edge the DUT sees a transfer.
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) sb.note_input(in_data);
		if (arst_n && out_valid && out_ready) sb.check_result(out_data);
	end

	// Watchdog: cycles with no transfer on either side.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WatchLimit) begin
			$display("k_nearest_point_indices_core: mismatch");
			$finish;
		end
	end

	// Receiver stall pattern, with one long hold-off while the sender keeps offering.
	initial begin
		int mode;
		out_ready <= 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_long) begin
				out_ready <= 0;
				repeat (3000) @(posedge clk);
				hold_long = 0;
			end
			mode = $urandom_range(0, 9);
			if (mode < 3) out_ready <= 1;
			else if (mode < 5) out_ready <= 0;
			else out_ready <= $urandom_range(0, 3) != 0;
		end
	end

	// One transfer; valid held until accepted.
	task automatic send(knpi_pkg::in_item_t it);
		in_valid <= 1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic gap();
		in_valid <= 0;
		repeat ($urandom_range(1, 6)) @(posedge clk);
	endtask

	function automatic knpi_pkg::in_item_t mk(knpi_pkg::cmd_t c);
		knpi_pkg::in_item_t it;
		logic [95:0] r;
		r = {$urandom, $urandom, $urandom};
		it = r[$bits(knpi_pkg::in_item_t)-1:0];
		it.cmd = c;
		return it;
	endfunction

	// Coordinates mostly clustered so distances tie or sit close, sometimes full range.
	function automatic logic [23:0] coord();
		case ($urandom_range(0, 4))
			0: return 24'($urandom);
			1: return $urandom_range(0, 1) ? 24'h7fffff : 24'h800000;
			default: return 24'($signed($urandom_range(0, 8)) - 4) <<< $urandom_range(0, 18);
		endcase
	endfunction

	function automatic knpi_pkg::in_item_t mk_load();
		knpi_pkg::in_item_t it;
		it = mk(knpi_pkg::CMD_LOAD);
		it.pos_x = coord();
		it.pos_y = coord();
		it.pos_z = coord();
		return it;
	endfunction

	function automatic knpi_pkg::in_item_t mk_query(int npts);
		knpi_pkg::in_item_t it;
		it = mk(knpi_pkg::CMD_QUERY);
		it.pos_x = coord();
		it.pos_y = coord();
		it.pos_z = coord();
		case ($urandom_range(0, 9))
			0: it.want_count = 7'($urandom_range(0, 127));
			1: it.want_count = 7'(npts + $urandom_range(0, 2));
			default:
				it.want_count = 7'($urandom_range(1,
					(npts < 1) ? 1 : (npts > 12 ? 12 : npts)));
		endcase
		return it;
	endfunction

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		knpi_pkg::in_item_t it;
		int n, burst;
		sb = new();
		sb.reset_state();
		in_valid <= 0;
		in_data <= '0;
		hold_long = 0;
		arst_n = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: empty query, extremes, ties, count edges, unused command.
		it = mk_query(0); it.want_count = 7'd1; send(it);
		it = mk(knpi_pkg::CMD_NONE); send(it);
		for (int i = 0; i < 6; i++) begin
			it = mk(knpi_pkg::CMD_LOAD);
			it.pos_x = (i % 2) ? 24'h7fffff : 24'h800000;
			it.pos_y = (i < 3) ? 24'h7fffff : 24'h800000;
			it.pos_z = (i == 5) ? 24'h7fffff : 24'h800000;
			it.excluded = 1'(i % 2);
			send(it);
		end
		it = mk_query(6); it.pos_x = 24'h7fffff; it.pos_y = 24'h800000;
		it.pos_z = 24'h7fffff; it.want_count = 7'd3; it.valence_only = 1'b0; send(it);
		it.want_count = 7'd3; it.valence_only = 1'b1; send(it);
		it.want_count = 7'd4; send(it);
		it.want_count = 7'd0; send(it);
		it.want_count = 7'd127; it.valence_only = 1'b0; send(it);
		it.want_count = 7'd6; send(it);
		it = mk(knpi_pkg::CMD_CLEAR); send(it);
		it = mk_query(0); it.want_count = 7'd1; send(it);
		drain();

		// Fill to capacity, then loads past full are dropped.
		for (int i = 0; i < knpi_pkg::MaxPoints + 3; i++) begin
			it = mk_load();
			send(it);
		end
		it = mk_query(256); it.want_count = 7'(knpi_pkg::MaxSelect);
		it.valence_only = 1'b0; send(it);
		it.want_count = 7'(knpi_pkg::MaxSelect + 1); send(it);
		drain();
		it = mk(knpi_pkg::CMD_CLEAR); send(it);

		// Random: bursts of loads and queries, with the odd clear or unused command, on small sets.
		hold_long = 1;
		n = 0;
		for (int item = 0; item < 150; ) begin
			burst = $urandom_range(1, 12);
			for (int b = 0; b < burst; b++) begin
				case ($urandom_range(0, 19))
					0: begin it = mk(knpi_pkg::CMD_CLEAR); n = 0; end
					1: it = mk(knpi_pkg::CMD_NONE);
					2, 3, 4, 5, 6, 7, 8, 9: begin
						it = mk_load();
						if (n < knpi_pkg::MaxPoints) n++;
					end
					default: it = mk_query(n);
				endcase
				if (n > 24 && $urandom_range(0, 3) == 0) begin
					it = mk(knpi_pkg::CMD_CLEAR);
					n = 0;
				end
				send(it);
				item++;
			end
			if ($urandom_range(0, 2) != 0) gap();
		end
		in_valid <= 0;

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (sb.errors == 0) $display("k_nearest_point_indices_core: match");
		else $display("k_nearest_point_indices_core: mismatch");
		$finish;
	end
endmodule
